FILE: design/gbt_pkg.sv
package gbt_pkg;

  localparam int VERT_W   = 5;
  localparam int WEIGHT_W = 32;
  localparam int CFG_W    = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_BFS    = 2'd2;
  localparam logic [1:0] OP_DFS    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]                 op;
    logic [VERT_W-1:0]          source_vertex;
    logic [VERT_W-1:0]          target_vertex;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic [VERT_W-1:0]          start_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VERT_W-1:0] visited_vertex;
    logic              last;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [VERT_W-1:0]          target;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

endpackage

FILE: design/graph_bfs_dfs_traversal_top.sv
// Insert and remove: scan and then shift the source vertex's entries, one entry
//   at a time, through the single edge RAM read port.
// Walk: a start step, then a pop and an emit per visited vertex plus a read and a
//   check per neighbor entry; one edge RAM read port and one shared compare path set the pace.
// One item at a time; in_stall stays high until the last result is taken.
// Synchronous active-low reset: empty lists, vertex_count = MAX_VERTICES, no clear pass.
module graph_bfs_dfs_traversal_top #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_DEGREE   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gbt_pkg::in_item_t      in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gbt_pkg::out_item_t     out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [gbt_pkg::CFG_W-1:0] cfg_data
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int DW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int WW  = $clog2(MAX_VERTICES + 1);
  localparam int AW  = VW + DW;
  localparam int DEPTH = 1 << AW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_SCANW  = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_SHIFTW = 4'd4;
  localparam logic [3:0] S_POP    = 4'd5;
  localparam logic [3:0] S_POPW   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_NRD    = 4'd8;
  localparam logic [3:0] S_NRDW   = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;
  localparam logic [3:0] S_NCHK   = 4'd11;

  logic [3:0]  state_r, state_nxt;
  gbt_pkg::in_item_t item_r, item_nxt;
  logic [WW-1:0] vcount_r, vcount_nxt;
  logic [CW-1:0] ncount_r [MAX_VERTICES];
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic [WW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [VW-1:0] cur_r, cur_nxt;
  logic [WW-1:0] emitted_r, emitted_nxt;
  gbt_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;
  logic nc_we; logic [VW-1:0] nc_addr; logic [CW-1:0] nc_val;

  logic ewe; logic [AW-1:0] ewa, era; gbt_pkg::edge_t ewd, erd;
  logic wwe; logic [VW-1:0] wwa, wra; logic [gbt_pkg::VERT_W-1:0] wwd, wrd;

  gbt_edge_ram #(.DEPTH(DEPTH), .ADDR_W(AW)) u_edges (
    .clk(clk), .wr_en(ewe), .wr_addr(ewa), .wr_data(ewd), .rd_addr(era), .rd_data(erd));
  gbt_work_ram #(.DEPTH(MAX_VERTICES), .ADDR_W(VW)) u_work (
    .clk(clk), .wr_en(wwe), .wr_addr(wwa), .wr_data(wwd), .rd_addr(wra), .rd_data(wrd));

  logic [VW-1:0] src;
  logic [CW-1:0] n_src, n_cur;
  logic src_ok, dst_ok, start_ok, tgt_ok;
  logic signed [gbt_pkg::WEIGHT_W-1:0] wt;

  assign src   = item_r.source_vertex[VW-1:0];
  assign n_src = ncount_r[src];
  assign n_cur = ncount_r[cur_r];
  assign wt    = item_r.edge_weight;
  assign src_ok = ({{(32-gbt_pkg::VERT_W){1'b0}}, item_r.source_vertex} < 32'(vcount_r));
  assign dst_ok = ({{(32-gbt_pkg::VERT_W){1'b0}}, item_r.target_vertex} < 32'(vcount_r));
  assign start_ok = ({{(32-gbt_pkg::VERT_W){1'b0}}, item_r.start_vertex} < 32'(vcount_r));
  assign tgt_ok = ({{(32-gbt_pkg::VERT_W){1'b0}}, erd.target} < 32'(vcount_r));

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r && !in_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  function automatic logic [AW-1:0] ea(input logic [VW-1:0] v, input logic [CW-1:0] i);
    ea = {v, i[DW-1:0]};
  endfunction

  // Sequencer: one edge RAM access and one compare per step
  always_comb begin
    state_nxt = state_r; item_nxt = item_r; vcount_nxt = vcount_r;
    idx_nxt = idx_r; pos_nxt = pos_r; vis_nxt = vis_r;
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r;
    emitted_nxt = emitted_r; out_nxt = out_r; out_valid_nxt = out_valid_r;
    status_nxt = status_r;
    nc_we = 1'b0; nc_addr = src; nc_val = n_src;
    ewe = 1'b0; ewa = ea(src, idx_r); ewd = '0; era = ea(src, idx_r);
    wwe = 1'b0; wwa = tail_r[VW-1:0]; wwd = '0; wra = head_r[VW-1:0];

    // Drop the result once taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          if (cfg_data == '0) vcount_nxt = WW'(1);
          else if (32'(cfg_data) > MAX_VERTICES) vcount_nxt = WW'(MAX_VERTICES);
          else vcount_nxt = WW'(cfg_data);
        end else if (in_valid && !in_stall) begin
          item_nxt = in_data; idx_nxt = '0; pos_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        case (item_r.op)
          gbt_pkg::OP_INSERT: begin
            if (!src_ok || !dst_ok || 32'(n_src) >= MAX_DEGREE) begin
              status_nxt = gbt_pkg::ST_FULL; state_nxt = S_RESP;
            end else if (n_src == '0) begin
              pos_nxt = '0; idx_nxt = '0; state_nxt = S_SHIFT;
            end else begin
              era = ea(src, idx_r); state_nxt = S_SCANW;
            end
          end
          gbt_pkg::OP_REMOVE: begin
            if (!src_ok || !dst_ok || idx_r >= n_src) begin
              status_nxt = gbt_pkg::ST_NOT_FOUND; state_nxt = S_RESP;
            end else begin
              era = ea(src, idx_r); state_nxt = S_SCANW;
            end
          end
          default: begin
            if (!start_ok) begin
              state_nxt = S_IDLE;
            end else begin
              vis_nxt = '0;
              wwe = 1'b1; wwa = '0; wwd = item_r.start_vertex;
              head_nxt = '0; tail_nxt = WW'(1); emitted_nxt = '0;
              state_nxt = S_POP;
            end
          end
        endcase
      end
      S_SCANW: begin
        if (item_r.op == gbt_pkg::OP_INSERT) begin
          // Find insert position
          if (idx_r == '0 && wt < erd.weight) begin
            pos_nxt = '0; idx_nxt = n_src; state_nxt = S_SHIFT;
          end else if (idx_r != '0 && !(wt > erd.weight)) begin
            pos_nxt = idx_r; idx_nxt = n_src; state_nxt = S_SHIFT;
          end else if (idx_r + CW'(1) >= n_src) begin
            pos_nxt = n_src; idx_nxt = n_src; state_nxt = S_SHIFT;
          end else begin
            idx_nxt = idx_r + CW'(1); state_nxt = S_SCAN;
          end
          if (n_src == '0) begin
            idx_nxt = '0;
          end
        end else begin
          if ({{(gbt_pkg::VERT_W){1'b0}}, erd.target} ==
              {{(gbt_pkg::VERT_W){1'b0}}, item_r.target_vertex}) begin
            pos_nxt = idx_r; state_nxt = S_SHIFT;
          end else begin
            idx_nxt = idx_r + CW'(1); state_nxt = S_SCAN;
          end
        end
      end
      S_SHIFT: begin
        if (item_r.op == gbt_pkg::OP_INSERT) begin
          // Move entries up from the tail down to pos
          if (idx_r > pos_r) begin
            era = ea(src, idx_r - CW'(1)); state_nxt = S_SHIFTW;
          end else begin
            ewe = 1'b1; ewa = ea(src, pos_r);
            ewd.target = item_r.target_vertex; ewd.weight = wt;
            nc_we = 1'b1; nc_val = n_src + CW'(1);
            status_nxt = gbt_pkg::ST_OK; state_nxt = S_RESP;
          end
        end else begin
          // Move entries down over the removed one
          if (pos_r + CW'(1) < n_src) begin
            era = ea(src, pos_r + CW'(1)); state_nxt = S_SHIFTW;
          end else begin
            nc_we = 1'b1; nc_val = n_src - CW'(1);
            status_nxt = gbt_pkg::ST_OK; state_nxt = S_RESP;
          end
        end
      end
      S_SHIFTW: begin
        ewe = 1'b1; ewd = erd;
        if (item_r.op == gbt_pkg::OP_INSERT) begin
          ewa = ea(src, idx_r); idx_nxt = idx_r - CW'(1);
        end else begin
          ewa = ea(src, pos_r); pos_nxt = pos_r + CW'(1);
        end
        state_nxt = S_SHIFT;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.visited_vertex = '0; out_nxt.last = 1'b1; out_nxt.status = status_r;
          out_valid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        // Take the next vertex from queue head or stack top
        if (item_r.op == gbt_pkg::OP_BFS) begin
          wra = head_r[VW-1:0]; head_nxt = head_r + WW'(1);
        end else begin
          wra = VW'(tail_r - WW'(1)); tail_nxt = tail_r - WW'(1);
        end
        state_nxt = S_POPW;
      end
      S_POPW: begin
        cur_nxt = wrd[VW-1:0];
        vis_nxt[wrd[VW-1:0]] = 1'b1;
        idx_nxt = '0;
        state_nxt = S_NRD;
      end
      S_NRD: begin
        if (idx_r < n_cur) begin
          era = ea(cur_r, idx_r); state_nxt = S_NRDW;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_NRDW: begin
        // Hold the read address so the entry is still on the port next cycle
        era = ea(cur_r, idx_r);
        state_nxt = S_NCHK;
      end
      S_NCHK: begin
        // Push an unvisited neighbor
        if (tgt_ok && !vis_r[erd.target[VW-1:0]] && 32'(tail_r) < MAX_VERTICES) begin
          vis_nxt[erd.target[VW-1:0]] = 1'b1;
          wwe = 1'b1; wwa = tail_r[VW-1:0]; wwd = erd.target;
          tail_nxt = tail_r + WW'(1);
        end
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_NRD;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.visited_vertex = gbt_pkg::VERT_W'(cur_r);
          out_nxt.status = gbt_pkg::ST_OK;
          emitted_nxt = emitted_r + WW'(1);
          out_nxt.last = !(tail_r > head_r && 32'(emitted_r) + 1 < MAX_VERTICES);
          out_valid_nxt = 1'b1;
          state_nxt = out_nxt.last ? S_IDLE : S_POP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      vcount_r <= WW'(MAX_VERTICES);
      for (int i = 0; i < MAX_VERTICES; i++) ncount_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vcount_r <= vcount_nxt;
      if (cfg_valid && cfg_ready) begin
        for (int i = 0; i < MAX_VERTICES; i++) ncount_r[i] <= '0;
      end else if (nc_we) begin
        ncount_r[nc_addr] <= nc_val;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt; idx_r <= idx_nxt; pos_r <= pos_nxt; vis_r <= vis_nxt;
    head_r <= head_nxt; tail_r <= tail_nxt; cur_r <= cur_nxt;
    emitted_r <= emitted_nxt; out_r <= out_nxt; status_r <= status_nxt;
  end

endmodule

FILE: design/gbt_edge_ram.sv
module gbt_edge_ram #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  gbt_pkg::edge_t      wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output gbt_pkg::edge_t      rd_data
);

  gbt_pkg::edge_t mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/gbt_work_ram.sv
module gbt_work_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [gbt_pkg::VERT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [gbt_pkg::VERT_W-1:0] rd_data
);

  logic [gbt_pkg::VERT_W-1:0] mem [DEPTH];

  // Queue or stack storage for a walk
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/gbt_checker.sv
module gbt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input gbt_pkg::out_item_t out_data,
  input logic cfg_valid,
  input logic cfg_ready
);

  // Stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // No new item is taken while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // Configuration only while no item is in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall)
    else $error("config ready while busy");

  // Configuration write and input transaction never coincide
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_ready && in_valid && !in_stall))
    else $error("config write during input transaction");

  // Error-status results carry vertex zero and are marked last
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != gbt_pkg::ST_OK |-> out_data.visited_vertex == '0
      && out_data.last)
    else $error("error status on walk result");

endmodule

bind graph_bfs_dfs_traversal_top gbt_checker u_gbt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready));
